@@ rtl/core/lpbc_pkg.sv @@
// shared types, action codes and brightness gain table for the pixel blink compositor
package lpbc_pkg;

	typedef enum logic [2:0] {
		ACT_ON        = 3'd0,
		ACT_OFF       = 3'd1,
		ACT_OFF_FORCE = 3'd2,
		ACT_BLINK     = 3'd3,
		ACT_TICK      = 3'd4,
		ACT_CLEAR     = 3'd5,
		ACT_READ      = 3'd6,
		ACT_SPARE     = 3'd7
	} action_t;

	localparam int unsigned BASE_W  = 24;
	// blink entry: active, lit, color 24, interval 16, due 32, left 11
	localparam int unsigned BLINK_W = 1 + 1 + 24 + 16 + 32 + 11;

	localparam logic [9:0]  REPS_MIN   = 10'd1;
	localparam logic [9:0]  REPS_MAX   = 10'd1000;
	localparam logic [15:0] PERIOD_MIN = 16'd10;
	localparam logic [15:0] PERIOD_MAX = 16'd60000;

	typedef struct packed {
		logic        active;
		logic        lit;
		logic [23:0] color;
		logic [15:0] interval;
		logic [31:0] due;
		logic [10:0] left;
	} blink_t;

	typedef logic [255:0][16:0] gain_tab_t;

	// (k/255)^3.2 in q1.16 for k = 0..255 (index 0 and 255 unused)
	function automatic logic [16:0] gain_q16(input logic [7:0] k);
		logic [63:0] x, lo, hi, mid, p, c;
		x  = ((64'(k) * 64'd65536) + 64'd127) / 64'd255;
		lo = 64'd0;
		hi = 64'd65536;
		for (int it = 0; it < 18; it++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				p = mid;
				for (int i = 0; i < 4; i++) p = (p * mid) >> 16;
				if (p <= x) lo = mid;
				else hi = mid - 64'd1;
			end
		end
		c = (x * x + 64'd32768) >> 16;
		c = (c * x + 64'd32768) >> 16;
		c = (c * lo + 64'd32768) >> 16;
		return c[16:0];
	endfunction

	function automatic gain_tab_t build_gain_tab();
		gain_tab_t t;
		for (int k = 0; k < 256; k++) t[k] = gain_q16(8'(k));
		return t;
	endfunction

	// gain lookup, evaluated at elaboration
	localparam gain_tab_t GAIN_Q16 = build_gain_tab();

endpackage

@@ rtl/core/lpbc_ram.sv @@
// generic single-port-write, one-read ram with registered read data
module lpbc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/lpbc_scale.sv @@
// two-stage brightness scaler: gain lookup, then per-channel multiply and round
module lpbc_scale
	import lpbc_pkg::*;
(
	input  logic        clk,
	input  logic        start,
	input  logic [7:0]  brightness,
	input  logic [23:0] rgb_color,
	output logic [23:0] scaled
);
	logic [16:0] gain_s1;
	logic [7:0]  k_s1;
	logic [23:0] rgb_s1;
	logic [23:0] res;

	always_ff @(posedge clk) begin
		if (start) begin
			gain_s1 <= GAIN_Q16[brightness];
			k_s1    <= brightness;
			rgb_s1  <= rgb_color;
		end
	end

	always_comb begin
		logic [25:0] prod;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			prod = 26'((25'(rgb_s1[ch*8 +: 8]) * 25'(gain_s1) + 25'd32768) >> 16);
			res[ch*8 +: 8] = (prod > 26'd255) ? 8'hFF : prod[7:0];
		end
		if (k_s1 == 8'd0) res = '0;
		else if (k_s1 == 8'hFF) res = rgb_s1;
	end

	always_ff @(posedge clk) scaled <= res;
endmodule

@@ rtl/core/led_pixel_blink_compositor_unit.sv @@
// top level: sequencer over base and blink memories
//  channel | dir | words
//  s_axis  | in  | action, pixel_index, color, brightness, repeats, period, now
//  m_axis  | out | status, pixel_color, refresh
//  cfg     | in  | active_pixels
// pixel actions step through read, scale, write, answer; read skips the write step
// tick and clear sweep every entry, one entry per cycle through the memory
// read and write ports
// after reset and after a pixel count change a clearing pass over all MAX_PIXELS
// entries runs before the first word is taken
// a waiting result holds s_axis_tready low until m_axis takes it
module led_pixel_blink_compositor_unit
	import lpbc_pkg::*;
#(
	parameter int unsigned MAX_PIXELS = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action 2:0, pixel_index 13:3, rgb_color 37:14, brightness 45:38,
	// blink_repeats 55:46, blink_period 71:56, now_time 103:72
	input  logic [103:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status 0, pixel_color 24:1, refresh 25
	output logic [31:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [11:0]  cfg_data
);
	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_SCALE, ST_WR, ST_SWEEP, ST_OUT
	} state_t;

	state_t      state_q;
	logic [AW:0] cnt_q;
	logic [11:0] npix_q;
	action_t     act_q;
	logic [10:0] idx_q;
	logic [23:0] rgb_q;
	logic [7:0]  bri_q;
	logic [9:0]  reps_q;
	logic [15:0] per_q;
	logic [31:0] now_q;
	logic        rd_valid_q;
	logic [AW-1:0] rd_addr_q;
	logic        status_q, refresh_q;
	logic [23:0] color_q;

	logic          base_we, blink_we;
	logic [AW-1:0] base_wa, blink_wa, raddr;
	logic [23:0]   base_wd, base_rd, scaled;
	blink_t        blink_wd, blink_rd;

	lpbc_ram #(.WIDTH(BASE_W), .DEPTH(MAX_PIXELS)) u_base (
		.clk(clk), .we(base_we), .waddr(base_wa), .wdata(base_wd),
		.raddr(raddr), .rdata(base_rd));
	lpbc_ram #(.WIDTH(BLINK_W), .DEPTH(MAX_PIXELS)) u_blink (
		.clk(clk), .we(blink_we), .waddr(blink_wa), .wdata(blink_wd),
		.raddr(raddr), .rdata(blink_rd));

	lpbc_scale u_scale (.clk(clk), .start(state_q == ST_RD), .brightness(bri_q),
		.rgb_color(rgb_q), .scaled(scaled));

	logic        in_range;
	assign in_range = (12'(idx_q) < npix_q) && (32'(idx_q) < MAX_PIXELS);

	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {6'd0, refresh_q, color_q, status_q};

	// clamped blink setup
	logic [9:0]  reps_c;
	logic [15:0] per_c;
	always_comb begin
		reps_c = (reps_q < REPS_MIN) ? REPS_MIN : (reps_q > REPS_MAX) ? REPS_MAX : reps_q;
		per_c  = (per_q < PERIOD_MIN) ? PERIOD_MIN :
		         (per_q > PERIOD_MAX) ? PERIOD_MAX : per_q;
	end

	// tick update of the entry whose read data is returning
	blink_t tick_wd;
	logic   tick_chg;
	always_comb begin
		logic [31:0] d;
		tick_wd  = blink_rd;
		tick_chg = 1'b0;
		d = now_q - blink_rd.due;
		if (blink_rd.active) begin
			if (blink_rd.left == 11'd0) begin
				tick_wd.active = 1'b0;
				tick_chg = 1'b1;
			end else if (!d[31]) begin
				tick_wd.lit  = !blink_rd.lit;
				tick_wd.left = blink_rd.left - 11'd1;
				tick_wd.due  = now_q + 32'(blink_rd.interval);
				tick_chg = 1'b1;
				if (tick_wd.left == 11'd0 && blink_rd.lit) tick_wd.active = 1'b0;
			end
		end
	end

	logic [AW-1:0] idx_a;
	assign idx_a = AW'(idx_q);
	assign raddr = (state_q == ST_SWEEP) ? cnt_q[AW-1:0] : idx_a;

	always_comb begin
		base_we  = 1'b0;
		base_wa  = idx_a;
		base_wd  = '0;
		blink_we = 1'b0;
		blink_wa = idx_a;
		blink_wd = blink_rd;
		unique case (state_q)
			ST_CLEAR: begin
				base_we = 1'b1; base_wa = cnt_q[AW-1:0];
				blink_we = 1'b1; blink_wa = cnt_q[AW-1:0]; blink_wd = '0;
			end
			ST_SWEEP: begin
				if (act_q == ACT_CLEAR) begin
					base_we = 1'b1; base_wa = cnt_q[AW-1:0];
					blink_we = 1'b1; blink_wa = cnt_q[AW-1:0]; blink_wd = '0;
				end else begin
					blink_we = rd_valid_q; blink_wa = rd_addr_q; blink_wd = tick_wd;
				end
			end
			ST_WR: begin
				if (in_range) begin
					unique case (act_q)
						ACT_OFF: base_we = !blink_rd.active;
						ACT_OFF_FORCE: begin
							base_we = 1'b1;
							blink_we = 1'b1;
							blink_wd.active = 1'b0;
							blink_wd.lit = 1'b0;
						end
						ACT_BLINK: begin
							blink_we = 1'b1;
							blink_wd.active   = 1'b1;
							blink_wd.lit      = 1'b1;
							blink_wd.color    = scaled;
							blink_wd.interval = per_c;
							blink_wd.due      = now_q + 32'(per_c);
							blink_wd.left     = 11'({reps_c, 1'b0} - 11'd1);
						end
						ACT_READ, ACT_TICK, ACT_CLEAR: ;
						default: begin
							base_we = !blink_rd.active;
							base_wd = scaled;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			npix_q     <= 12'd2048;
			rd_valid_q <= 1'b0;
			status_q   <= 1'b0;
			refresh_q  <= 1'b0;
			color_q    <= '0;
			act_q      <= ACT_ON;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == (AW+1)'(MAX_PIXELS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_IDLE: begin
					if (cfg_valid) begin
						npix_q <= cfg_data;
						if (cfg_data != npix_q) begin
							cnt_q <= '0;
							state_q <= ST_CLEAR;
						end
					end else if (s_axis_tvalid) begin
						act_q  <= action_t'(s_axis_tdata[2:0]);
						idx_q  <= s_axis_tdata[13:3];
						rgb_q  <= s_axis_tdata[37:14];
						bri_q  <= s_axis_tdata[45:38];
						reps_q <= s_axis_tdata[55:46];
						per_q  <= s_axis_tdata[71:56];
						now_q  <= s_axis_tdata[103:72];
						cnt_q  <= '0;
						rd_valid_q <= 1'b0;
						status_q  <= 1'b0;
						refresh_q <= 1'b0;
						color_q   <= '0;
						if (s_axis_tdata[2:0] == ACT_TICK || s_axis_tdata[2:0] == ACT_CLEAR)
							state_q <= ST_SWEEP;
						else state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_SCALE;
				ST_SCALE: begin
					// memory data valid here; read answers now
					if (act_q == ACT_READ) begin
						if (in_range)
							color_q <= (blink_rd.active && blink_rd.lit) ?
								blink_rd.color : base_rd;
						else status_q <= 1'b1;
						state_q <= ST_OUT;
					end else state_q <= ST_WR;
				end
				ST_WR: begin
					status_q  <= !in_range;
					refresh_q <= in_range;
					state_q   <= ST_OUT;
				end
				ST_SWEEP: begin
					if (act_q == ACT_CLEAR) begin
						refresh_q <= 1'b1;
						if (cnt_q == (AW+1)'(MAX_PIXELS - 1)) state_q <= ST_OUT;
						else cnt_q <= cnt_q + 1'b1;
					end else begin
						if (rd_valid_q && tick_chg) refresh_q <= 1'b1;
						rd_addr_q <= cnt_q[AW-1:0];
						if (cnt_q == (AW+1)'(MAX_PIXELS)) begin
							rd_valid_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							rd_valid_q <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ verif/lpbc_checker.sv @@
// checker: watches the pixel compositor channels, predicts every answer and compares it
`timescale 1ns / 100ps
module lpbc_checker
	import lpbc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [31:0]  m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [11:0]  cfg_data,
	output int           errors,
	output int           waiting
);
	localparam int NPIX = 2048;

	typedef struct packed {
		logic        status;
		logic [23:0] color;
		logic        refresh;
	} answer_t;

	answer_t     answers_due[$];
	logic [11:0] strip_pixels;
	logic [23:0] base_rgb [NPIX];
	logic        bl_on [NPIX];
	logic        bl_lit [NPIX];
	logic [23:0] bl_rgb [NPIX];
	logic [15:0] bl_ms [NPIX];
	logic [31:0] bl_due [NPIX];
	logic [10:0] bl_left [NPIX];
	logic [16:0] gamma_q16 [256];

	function automatic logic [16:0] calc_gamma(input int k);
		longint unsigned x, lo, hi, mid, p, c;
		x = (longint'(k) * 65536 + 127) / 255;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			p = mid;
			repeat (4) p = (p * mid) >> 16;
			if (p <= x) lo = mid;
			else hi = mid - 1;
		end
		c = (x * x + 32768) >> 16;
		c = (c * x + 32768) >> 16;
		c = (c * lo + 32768) >> 16;
		return c[16:0];
	endfunction

	function automatic logic [23:0] dim_rgb(input logic [7:0] k, input logic [23:0] rgb);
		logic [23:0] res;
		longint unsigned s;
		res = '0;
		if (k == 8'd0) return 24'd0;
		if (k == 8'd255) return rgb;
		for (int ch = 0; ch < 3; ch++) begin
			s = (longint'(rgb[ch*8 +: 8]) * gamma_q16[k] + 32768) >> 16;
			if (s > 255) s = 255;
			res[ch*8 +: 8] = s[7:0];
		end
		return res;
	endfunction

	function automatic void wipe_strip();
		for (int p = 0; p < NPIX; p++) begin
			base_rgb[p] = '0;
			bl_on[p] = 1'b0;
			bl_lit[p] = 1'b0;
		end
	endfunction

	function automatic answer_t predict_answer(input logic [103:0] w);
		action_t     act;
		logic [10:0] idx;
		logic [23:0] rgb, dimmed;
		logic [7:0]  k;
		logic [9:0]  reps;
		logic [15:0] ms;
		logic [31:0] now, diff;
		int          lim;
		answer_t     a;
		act = action_t'(w[2:0]);
		idx = w[13:3];
		rgb = w[37:14];
		k = w[45:38];
		reps = w[55:46];
		ms = w[71:56];
		now = w[103:72];
		lim = strip_pixels > NPIX ? NPIX : strip_pixels;
		a = '0;
		if (act == ACT_TICK) begin
			for (int p = 0; p < NPIX; p++) begin
				if (!bl_on[p]) continue;
				if (bl_left[p] == 0) begin
					bl_on[p] = 1'b0;
					a.refresh = 1'b1;
					continue;
				end
				diff = now - bl_due[p];
				if (diff[31]) continue;
				bl_lit[p] = !bl_lit[p];
				bl_left[p] = bl_left[p] - 11'd1;
				bl_due[p] = now + 32'(bl_ms[p]);
				a.refresh = 1'b1;
				if (bl_left[p] == 0 && !bl_lit[p]) bl_on[p] = 1'b0;
			end
		end else if (act == ACT_CLEAR) begin
			wipe_strip();
			a.refresh = 1'b1;
		end else if (int'(idx) >= lim) begin
			a.status = 1'b1;
		end else if (act == ACT_READ) begin
			a.color = (bl_on[idx] && bl_lit[idx]) ? bl_rgb[idx] : base_rgb[idx];
		end else begin
			dimmed = dim_rgb(k, rgb);
			a.refresh = 1'b1;
			case (act)
				ACT_OFF: begin
					if (!bl_on[idx]) base_rgb[idx] = '0;
				end
				ACT_OFF_FORCE: begin
					bl_on[idx] = 1'b0;
					bl_lit[idx] = 1'b0;
					base_rgb[idx] = '0;
				end
				ACT_BLINK: begin
					if (reps < REPS_MIN) reps = REPS_MIN;
					if (reps > REPS_MAX) reps = REPS_MAX;
					if (ms < PERIOD_MIN) ms = PERIOD_MIN;
					if (ms > PERIOD_MAX) ms = PERIOD_MAX;
					bl_on[idx] = 1'b1;
					bl_lit[idx] = 1'b1;
					bl_rgb[idx] = dimmed;
					bl_ms[idx] = ms;
					bl_due[idx] = now + 32'(ms);
					bl_left[idx] = {reps, 1'b0} - 11'd1;
				end
				default: begin
					// on and the spare code
					if (!bl_on[idx]) base_rgb[idx] = dimmed;
				end
			endcase
		end
		return a;
	endfunction

	initial begin
		for (int k = 0; k < 256; k++) gamma_q16[k] = calc_gamma(k);
		strip_pixels = 12'd2048;
		wipe_strip();
		errors = 0;
	end

	assign waiting = answers_due.size();

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_data != strip_pixels) wipe_strip();
				strip_pixels = cfg_data;
			end
			if (s_tvalid && s_tready)
				answers_due.insert(answers_due.size(), predict_answer(s_tdata));
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					$error("answer word with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (m_tdata[0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[0]);
						errors++;
					end
					if (m_tdata[24:1] !== want.color) begin
						$error("pixel_color: expected %h, got %h", want.color, m_tdata[24:1]);
						errors++;
					end
					if (m_tdata[25] !== want.refresh) begin
						$error("refresh: expected %0d, got %0d", want.refresh, m_tdata[25]);
						errors++;
					end
				end
			end
		end
	end
endmodule

@@ verif/tb.sv @@
// testbench top: clock, reset, stimulus for the pixel compositor and the verdict
`timescale 1ns / 100ps
module tb;
	import lpbc_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         cfg_valid, cfg_ready;
	logic [11:0]  cfg_data;
	int           errors, waiting;
	int           quiet_cycles;
	int           rx_stall;
	logic         no_gaps;
	logic [31:0]  clock_ms;
	int           strip_len;

	led_pixel_blink_compositor_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	lpbc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls drawn per answer word
	always @(posedge clk or negedge arst_n) begin
		int nxt;
		if (!arst_n) begin
			rx_stall <= 0;
			m_axis_tready <= 1'b0;
		end else begin
			nxt = rx_stall;
			if (m_axis_tvalid && m_axis_tready) nxt = no_gaps ? 0 : $urandom_range(0, 11);
			if (nxt > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall <= nxt - 1;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 30000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(input action_t act, input logic [10:0] idx,
			input logic [23:0] rgb, input logic [7:0] k, input logic [9:0] reps,
			input logic [15:0] ms);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {clock_ms, ms, reps, k, rgb, idx, act};
		do @(posedge clk); while (!s_axis_tready);
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one edge first so the checker has taken the last accepted word
	task automatic drain();
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	task automatic set_pixel_count(input logic [11:0] v);
		s_axis_tvalid <= 1'b0;
		drain();
		repeat (12) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		strip_len = v > 2048 ? 2048 : v;
	endtask

	task automatic random_word();
		int          pick;
		action_t     act;
		logic [10:0] idx;
		logic [7:0]  k;
		logic [9:0]  reps;
		logic [15:0] ms;
		pick = $urandom_range(0, 99);
		if (pick < 20) act = ACT_ON;
		else if (pick < 30) act = ACT_OFF;
		else if (pick < 35) act = ACT_OFF_FORCE;
		else if (pick < 50) act = ACT_BLINK;
		else if (pick < 62) act = ACT_TICK;
		else if (pick < 64) act = ACT_CLEAR;
		else if (pick < 97) act = ACT_READ;
		else act = ACT_SPARE;
		// mostly a small cluster of live pixels so blinks get read back
		if (strip_len > 0 && $urandom_range(0, 4) != 0)
			idx = 11'($urandom_range(0, (strip_len > 24 ? 24 : strip_len) - 1));
		else idx = 11'($urandom);
		pick = $urandom_range(0, 9);
		k = pick == 0 ? 8'd0 : pick == 1 ? 8'd255 : 8'($urandom);
		reps = $urandom_range(0, 4) != 0 ? 10'($urandom_range(0, 3)) : 10'($urandom);
		ms = $urandom_range(0, 4) != 0 ? 16'($urandom_range(0, 40)) : 16'($urandom);
		if (act == ACT_TICK) clock_ms = clock_ms + $urandom_range(0, 25);
		if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
		send_word(act, idx, 24'($urandom), k, reps, ms);
	endtask

	initial begin
		logic [11:0] counts [6] = '{12'd16, 12'd1, 12'd4095, 12'd0, 12'd300, 12'd2048};
		int          lens [6] = '{500, 150, 400, 40, 350, 300};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		no_gaps = 1'b0;
		quiet_cycles = 0;
		strip_len = 2048;
		clock_ms = 32'hFFFF_FFE0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every action, blink life just below the time wrap
		send_word(ACT_READ, 11'd0, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_ON, 11'd0, 24'hFFFFFF, 8'd255, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd0, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_ON, 11'd2047, 24'hFFFFFF, 8'd0, 10'd1023, 16'hFFFF);
		send_word(ACT_ON, 11'd5, 24'hFF8001, 8'd128, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd5, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_OFF, 11'd5, 24'h0, 8'd1, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd5, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_BLINK, 11'd7, 24'h12AB34, 8'd254, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd7, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_ON, 11'd7, 24'h00FF00, 8'd255, 10'd0, 16'd0);
		send_word(ACT_OFF, 11'd7, 24'h0, 8'd0, 10'd0, 16'd0);
		clock_ms = clock_ms + 5;
		send_word(ACT_TICK, 11'd7, 24'h0, 8'd0, 10'd0, 16'd0);
		clock_ms = clock_ms + 5;
		send_word(ACT_TICK, 11'd3, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd7, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_BLINK, 11'd9, 24'hFFFFFF, 8'd255, 10'd1023, 16'hFFFF);
		send_word(ACT_BLINK, 11'd9, 24'hA5A5A5, 8'd200, 10'd2, 16'd11);
		send_word(ACT_OFF_FORCE, 11'd9, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_SPARE, 11'd10, 24'h5A5A5A, 8'd77, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd10, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_CLEAR, 11'd0, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_READ, 11'd0, 24'h0, 8'd0, 10'd0, 16'd0);
		set_pixel_count(12'd4);
		send_word(ACT_READ, 11'd4, 24'h0, 8'd0, 10'd0, 16'd0);
		send_word(ACT_BLINK, 11'd2047, 24'hFFFFFF, 8'd255, 10'd1, 16'd10);
		send_word(ACT_ON, 11'd3, 24'hFFFFFF, 8'd255, 10'd0, 16'd0);

		// random phases, one per pixel count
		for (int ph = 0; ph < 6; ph++) begin
			set_pixel_count(counts[ph]);
			if (ph == 2) set_pixel_count(counts[ph]);
			for (int n = 0; n < lens[ph]; n++) begin
				if (n % 60 == 0) no_gaps = $urandom_range(0, 2) == 0;
				if (ph == 0 && n == 250) begin
					s_axis_tvalid <= 1'b0;
					drain();
					@(posedge clk);
				end
				random_word();
			end
		end
		s_axis_tvalid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
